>>> rtl/lqps_pkg.sv
// Package for the line query prefix scorer: sizes, codes, the line record
// handed from front end to back end. Used by every module under rtl but lqps_log2.
package lqps_pkg;
  localparam int MaxLineBytes = 1024;
  localparam int QuerySlots   = 4;
  localparam int QueryChars   = 8;
  localparam int CountMax     = 1023;
  localparam int LogFrac      = 24;
  localparam int NormShift    = 30;
  localparam int ScoreFrac    = 12;

  localparam logic [7:0] CharLf = 8'd10;
  localparam logic [7:0] CharCr = 8'd13;

  localparam logic [2:0] RegActive = 3'd0;
  localparam logic [2:0] RegQuery0 = 3'd1;

  typedef struct packed {
    logic [23:0] line_number;
    logic [10:0] byte_count;
    logic [9:0]  words;
    logic [2:0]  used;
    logic [QuerySlots-1:0][9:0] tally;
  } line_rec_t;
endpackage

>>> rtl/lqps_front.sv
// Front end: counts bytes, words and query prefix matches per line.
// Depends on lqps_pkg; pushes one line_rec_t per finished non-empty line.
module lqps_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [7:0] char_code,
  input  logic [2:0] active_queries,
  input  logic [lqps_pkg::QuerySlots-1:0][63:0] query_words,
  output logic rec_valid,
  output lqps_pkg::line_rec_t rec
);
  logic [23:0] line_r;
  logic [10:0] bytes_r;
  logic [9:0]  words_r;
  logic        inword_r;
  logic [lqps_pkg::QuerySlots-1:0][3:0] pos_r;
  logic [lqps_pkg::QuerySlots-1:0]      skip_r;
  logic [lqps_pkg::QuerySlots-1:0][9:0] tally_r;

  logic alnum;
  logic [7:0] folded;
  assign alnum = (char_code >= "0" && char_code <= "9") ||
                 (char_code >= "A" && char_code <= "Z") ||
                 (char_code >= "a" && char_code <= "z");
  assign folded = (char_code >= "A" && char_code <= "Z") ? char_code + 8'd32 : char_code;

  logic is_lf, is_cr;
  assign is_lf = char_code == lqps_pkg::CharLf;
  assign is_cr = char_code == lqps_pkg::CharCr;

  logic [9:0] words_end;
  assign words_end = (inword_r && words_r != 10'(lqps_pkg::CountMax)) ?
                     words_r + 10'd1 : words_r;

  always_comb begin
    rec_valid       = in_valid && is_lf && bytes_r != 11'd0;
    rec.line_number = line_r;
    rec.byte_count  = bytes_r;
    rec.words       = words_end;
    rec.used        = (active_queries > 3'(lqps_pkg::QuerySlots)) ?
                      3'(lqps_pkg::QuerySlots) : active_queries;
    rec.tally       = tally_r;
  end

  logic [lqps_pkg::QuerySlots-1:0][3:0] len;
  logic [lqps_pkg::QuerySlots-1:0][3:0] pos_nxt;
  logic [lqps_pkg::QuerySlots-1:0]      skip_nxt;
  logic [lqps_pkg::QuerySlots-1:0][9:0] tally_nxt;

  always_comb begin
    logic stop;
    logic [7:0] qb;
    for (int k = 0; k < lqps_pkg::QuerySlots; k++) begin
      len[k] = 4'd0;
      stop = 1'b0;
      for (int j = 0; j < lqps_pkg::QueryChars; j++) begin
        if (!stop && query_words[k][8*j +: 8] != 8'd0) len[k] = 4'(j + 1);
        else stop = 1'b1;
      end
      pos_nxt[k] = pos_r[k];
      skip_nxt[k] = skip_r[k];
      tally_nxt[k] = tally_r[k];
      qb = query_words[k][8*pos_r[k][2:0] +: 8];
      if (len[k] == 4'd0) begin
        pos_nxt[k] = 4'd0;
        skip_nxt[k] = 1'b0;
      end else if (skip_r[k]) begin
        if (!alnum) skip_nxt[k] = 1'b0;
      end else if (pos_r[k] < len[k] && qb == folded) begin
        if (pos_r[k] + 4'd1 >= len[k]) begin
          if (tally_r[k] != 10'(lqps_pkg::CountMax)) tally_nxt[k] = tally_r[k] + 10'd1;
          pos_nxt[k] = 4'd0;
          skip_nxt[k] = alnum;
        end else begin
          pos_nxt[k] = pos_r[k] + 4'd1;
        end
      end else begin
        pos_nxt[k] = 4'd0;
        skip_nxt[k] = alnum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 24'd1;
      bytes_r <= '0;
      words_r <= '0;
      inword_r <= 1'b0;
      pos_r <= '0;
      skip_r <= '0;
      tally_r <= '0;
    end else if (in_valid && !is_cr) begin
      if (is_lf) begin
        line_r <= line_r + 24'd1;
        bytes_r <= '0;
        words_r <= '0;
        inword_r <= 1'b0;
        pos_r <= '0;
        skip_r <= '0;
        tally_r <= '0;
      end else begin
        if (bytes_r != 11'(lqps_pkg::MaxLineBytes)) bytes_r <= bytes_r + 11'd1;
        if (alnum) inword_r <= 1'b1;
        else if (inword_r) begin
          inword_r <= 1'b0;
          if (words_r != 10'(lqps_pkg::CountMax)) words_r <= words_r + 10'd1;
        end
        pos_r <= pos_nxt;
        skip_r <= skip_nxt;
        tally_r <= tally_nxt;
      end
    end
  end
endmodule

>>> rtl/lqps_fifo.sv
// Short queue of line records between front and back end.
// Depends on lqps_pkg for line_rec_t.
module lqps_fifo (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  lqps_pkg::line_rec_t wdata,
  output logic full,
  input  logic rd,
  output logic nonempty,
  output lqps_pkg::line_rec_t rdata
);
  lqps_pkg::line_rec_t mem_r [4];
  logic [2:0] wp_r, rp_r;
  assign full = (wp_r - rp_r) == 3'd4;
  assign nonempty = wp_r != rp_r;
  assign rdata = mem_r[rp_r[1:0]];
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r[1:0]] <= wdata;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 3'd1;
      if (rd) rp_r <= rp_r + 3'd1;
    end
  end
`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr) else $error("fifo overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !nonempty |-> !rd) else $error("fifo underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) <= 3'd4) else $error("fifo count");
`endif
endmodule

>>> rtl/lqps_log2.sv
// Iterative log2 in Q.24 by repeated squaring, one square per cycle.
// Depends on nothing outside; shared by the back end for all terms.
module lqps_log2 (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [19:0] x,
  output logic done,
  output logic [28:0] result
);
  logic [31:0] y_r;
  logic [28:0] r_r;
  logic [4:0]  i_r;
  logic        busy_r;
  logic [4:0]  n;
  logic [63:0] sq;
  assign sq = 64'(y_r) * 64'(y_r);

  always_comb begin
    n = 5'd0;
    for (int b = 1; b < 20; b++) if (x[b]) n = 5'(b);
  end

  assign done = busy_r && i_r == 5'd0;
  assign result = r_r;

  always_ff @(posedge clk) begin
    logic [33:0] t;
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      y_r <= 32'(x) << (5'd30 - n);
      r_r <= (x == 20'd0) ? 29'd0 : {n, 24'd0};
      i_r <= (x == 20'd0) ? 5'd0 : 5'd24;
    end else if (busy_r && i_r != 5'd0) begin
      t = 34'(sq >> 30);
      if (t[31]) begin
        y_r <= t[32:1];
        r_r[i_r - 5'd1] <= 1'b1;
      end else y_r <= t[31:0];
      i_r <= i_r - 5'd1;
    end else busy_r <= 1'b0;
  end
endmodule

>>> rtl/lqps_back.sv
// Back end: sums log2 terms, takes denominator log, divides restoring.
// Depends on lqps_pkg and lqps_log2; feeds a one-entry output register.
module lqps_back (
  input  logic clk,
  input  logic rst_n,
  input  logic rec_avail,
  input  lqps_pkg::line_rec_t rec,
  output logic rec_take,
  output logic out_empty,
  input  logic out_pop,
  output logic [23:0] out_line_number,
  output logic [10:0] out_byte_count,
  output logic [9:0]  out_words,
  output logic [15:0] out_score
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NUM  = 3'd1;
  localparam logic [2:0] S_DEN  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_r;
  logic        go_r;
  logic [2:0]  k_r;
  logic [31:0] num_r;
  logic [28:0] den_r;
  logic [44:0] quo_r;
  logic [44:0] rem_r;
  logic [5:0]  bit_r;
  lqps_pkg::line_rec_t rec_r;
  logic        full_r;
  logic [15:0] score_r;

  logic [19:0] lx;
  logic        ldone;
  logic [28:0] lres;
  lqps_log2 u_log (.clk, .rst_n, .start(go_r), .x(lx), .done(ldone), .result(lres));

  assign lx = (state_r == S_DEN) ? 20'd17 + {9'd0, rec_r.words, 1'b0}
                                 : 20'd1 + 20'(rec_r.tally[k_r[1:0]]);
  assign rec_take = state_r == S_IDLE && rec_avail;
  assign out_empty = !full_r;

  logic [44:0] dividend;
  assign dividend = {1'b0, num_r, 12'd0};
  logic [44:0] trial;
  assign trial = {rem_r[43:0], dividend[bit_r]};

  always_ff @(posedge clk) begin
    if (rec_take) rec_r <= rec;
    if (state_r == S_OUT && !full_r) begin
      out_line_number <= rec_r.line_number;
      out_byte_count  <= rec_r.byte_count;
      out_words       <= rec_r.words;
      out_score       <= score_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r <= 1'b0;
      full_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (out_pop && full_r) full_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (rec_avail) begin
          num_r <= '0;
          k_r <= '0;
          state_r <= S_NUM;
          go_r <= 1'b1;
        end
        S_NUM: begin
          if (k_r >= rec_r.used) begin
            state_r <= S_DEN;
            go_r <= 1'b1;
          end else if (ldone && !go_r) begin
            num_r <= num_r + 32'(lres);
            k_r <= k_r + 3'd1;
            go_r <= 1'b1;
          end
        end
        S_DEN: if (ldone && !go_r) begin
          den_r <= lres - 29'(1 << lqps_pkg::LogFrac);
          rem_r <= '0;
          quo_r <= '0;
          bit_r <= 6'd44;
          if (lres == 29'(1 << lqps_pkg::LogFrac)) begin
            score_r <= 16'hFFFF;
            state_r <= S_OUT;
          end else state_r <= S_DIV;
        end
        S_DIV: begin
          if (trial >= 45'(den_r)) begin
            rem_r <= trial - 45'(den_r);
            quo_r[bit_r] <= 1'b1;
          end else rem_r <= trial;
          if (bit_r == 6'd0) begin
            // bit 0 lands in quo_r at this edge; fold it in and saturate
            score_r <= (quo_r[44:16] != 29'd0) ? 16'hFFFF
                     : (quo_r[15:0] | {15'd0, trial >= 45'(den_r)});
            state_r <= S_OUT;
          end else bit_r <= bit_r - 6'd1;
        end
        S_OUT: begin
          if (!full_r) begin
            full_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
`ifndef SYNTH
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rec_take |=> state_r == S_NUM) else $error("take without start");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && !out_pop) |=> full_r && $stable(out_score)) else $error("out lost");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> den_r != 29'd0) else $error("zero divisor");
`endif
endmodule

>>> rtl/line_query_prefix_scorer.sv
// Channel | handshake           | payload
// input   | in_push / in_full   | in_char_code[7:0]
// result  | out_pop / out_empty | out_line_number, out_byte_count, out_words, out_score
// config  | APB cfg_*           | active_queries @0, query_word_0..3 @8..32 (64-bit data)
// Bytes are taken one per cycle while in_full is low; in_full rises only when four
// finished lines wait in the queue for the back end. Per line the back end takes the
// record, one log per active query, the denominator log, a divide and the output load.
// A result not yet popped holds the back end in its output state.
// Reset is synchronous on rst_n and clears counters, queue and output.
module line_query_prefix_scorer (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [7:0] in_char_code,
  output logic out_empty,
  input  logic out_pop,
  output logic [23:0] out_line_number,
  output logic [10:0] out_byte_count,
  output logic [9:0]  out_words,
  output logic [15:0] out_score,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [5:0] cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic cfg_pready
);
  logic [2:0] active_r;
  logic [lqps_pkg::QuerySlots-1:0][63:0] query_r;
  logic [2:0] ridx;
  assign ridx = cfg_paddr[5:3];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 3'd1;
      query_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (ridx == lqps_pkg::RegActive) active_r <= cfg_pwdata[2:0];
      else if (ridx <= 3'(lqps_pkg::QuerySlots))
        query_r[2'(ridx - lqps_pkg::RegQuery0)] <= cfg_pwdata;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (ridx == lqps_pkg::RegActive) cfg_prdata = {61'd0, active_r};
    else if (ridx <= 3'(lqps_pkg::QuerySlots))
      cfg_prdata = query_r[2'(ridx - lqps_pkg::RegQuery0)];
  end

  logic acc, rv, qfull, qne, take;
  lqps_pkg::line_rec_t rec, qrec;
  assign in_full = qfull;
  assign acc = in_push && !qfull;

  lqps_front u_front (.clk, .rst_n, .in_valid(acc), .char_code(in_char_code),
    .active_queries(active_r), .query_words(query_r), .rec_valid(rv), .rec);
  lqps_fifo u_fifo (.clk, .rst_n, .wr(rv), .wdata(rec), .full(qfull),
    .rd(take), .nonempty(qne), .rdata(qrec));
  lqps_back u_back (.clk, .rst_n, .rec_avail(qne), .rec(qrec), .rec_take(take),
    .out_empty, .out_pop, .out_line_number, .out_byte_count, .out_words,
    .out_score);
endmodule
